// ===== sv/egpbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge-gated pixel blend filter package
// Shared widths, configuration register indexes, reset values and the
// result record type of the edge-gated pixel blend filter.
// ----------------------------------------------------------------------------
package egpbf_pkg;

  // Pixel and field widths.
  localparam int PIX_W   = 24;
  localparam int CH_W    = 8;
  localparam int ROW_W   = 16;
  localparam int COL_O_W = 10;
  localparam int THR_W   = 10;
  localparam int FW_W    = 11;
  localparam int FH_W    = 16;

  // Default line buffer depth (widest row).
  localparam int MAX_WIDTH_DEF = 1024;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_EDGE_THRESHOLD = 2'd0;
  localparam cfg_idx_t CFG_FRAME_WIDTH    = 2'd1;
  localparam cfg_idx_t CFG_FRAME_HEIGHT   = 2'd2;

  // Register values after reset.
  localparam logic [THR_W-1:0] THR_RESET = 10'd30;
  localparam logic [FW_W-1:0]  FW_RESET  = 11'd1024;
  localparam logic [FH_W-1:0]  FH_RESET  = 16'd768;

  // Smallest frame side the filter works with.
  localparam int MIN_SIDE = 3;

  // Result queue.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t               pixel;
    logic [ROW_W-1:0]   row;
    logic [COL_O_W-1:0] col;
    logic               last;
  } res_t;

endpackage

// ===== sv/egpbf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic line buffer RAM
// One write port and two read ports, both reads registered. A read of the
// entry being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module egpbf_ram #(
  parameter int WIDTH = egpbf_pkg::PIX_W,
  parameter int DEPTH = egpbf_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  // Storage write and registered reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_r[rd_addr_a];
    rd_b_r <= mem_r[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ===== sv/edge_gated_pixel_blend_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge-gated pixel blend filter
// Raster-order 0xRRGGBB filter that blends interior pixels across edges,
// using two line buffers in block RAM.
// ----------------------------------------------------------------------------
// The filter takes one pixel per clock when not stalled and returns, for each
// pixel of row r, the filtered pixel at the same column of row r-1, tagged with
// its row and column; row 0 produces nothing, and in the last row each input
// also produces itself as a second result, so there the input side runs at the
// output rate of one result per clock. A result passes through stage one and
// then waits in a four-entry result queue; the input stalls whenever the queue,
// counting the results still on their way in, has fewer than two free entries.
// The line buffers need no clearing after reset.
// The user must write configuration only while the filter is idle; the filter
// does not enforce this.
module edge_gated_pixel_blend_filter #(
  parameter int MAX_WIDTH = egpbf_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Pixel input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [egpbf_pkg::PIX_W-1:0]         in_pixel_in,
  // Result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [egpbf_pkg::PIX_W-1:0]         out_pixel_out,
  output logic [egpbf_pkg::ROW_W-1:0]         out_row_out,
  output logic [egpbf_pkg::COL_O_W-1:0]       out_col_out,
  output logic                                out_run_last,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  egpbf_pkg::cfg_idx_t                 cfg_index,
  input  logic [egpbf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = ($clog2(MAX_WIDTH + 1) > egpbf_pkg::FW_W) ?
                         $clog2(MAX_WIDTH + 1) : egpbf_pkg::FW_W;
  localparam int RW    = egpbf_pkg::ROW_W;
  localparam int OAW   = egpbf_pkg::OQ_AW;
  localparam int CW    = egpbf_pkg::OQ_AW + 1;
  localparam int CH    = egpbf_pkg::CH_W;

  // Sum of absolute channel differences of two pixels.
  function automatic logic [9:0] colour_dist(egpbf_pkg::pix_t p, egpbf_pkg::pix_t q);
    logic [9:0] acc;
    logic [CH-1:0] a;
    logic [CH-1:0] b;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      a = p[k*CH +: CH];
      b = q[k*CH +: CH];
      acc = acc + 10'((a > b) ? (a - b) : (b - a));
    end
    return acc;
  endfunction

  // Mean of the four neighbors, then mean with the center, both truncated.
  function automatic egpbf_pkg::pix_t blend(egpbf_pkg::pix_t c, egpbf_pkg::pix_t l,
                                            egpbf_pkg::pix_t r, egpbf_pkg::pix_t a,
                                            egpbf_pkg::pix_t b);
    egpbf_pkg::pix_t res;
    logic [CH+1:0] sum4;
    logic [CH:0]   sum2;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      sum4 = (CH+2)'(l[k*CH +: CH]) + (CH+2)'(r[k*CH +: CH]) +
             (CH+2)'(a[k*CH +: CH]) + (CH+2)'(b[k*CH +: CH]);
      sum2 = (CH+1)'(sum4[CH+1:2]) + (CH+1)'(c[k*CH +: CH]);
      res[k*CH +: CH] = sum2[CH:1];
    end
    return res;
  endfunction

  // Configuration registers.
  logic [egpbf_pkg::THR_W-1:0] thresh_r;
  logic [egpbf_pkg::FW_W-1:0]  fwidth_r;
  logic [egpbf_pkg::FH_W-1:0]  fheight_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= egpbf_pkg::THR_RESET;
      fwidth_r  <= egpbf_pkg::FW_RESET;
      fheight_r <= egpbf_pkg::FH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        egpbf_pkg::CFG_EDGE_THRESHOLD: thresh_r  <= cfg_data[egpbf_pkg::THR_W-1:0];
        egpbf_pkg::CFG_FRAME_WIDTH:    fwidth_r  <= cfg_data[egpbf_pkg::FW_W-1:0];
        egpbf_pkg::CFG_FRAME_HEIGHT:   fheight_r <= cfg_data[egpbf_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame size in use.
  logic [WW-1:0] fw_ext;
  logic [WW-1:0] w_use;
  logic [RW-1:0] h_use;
  logic [RW:0]   h_ext;

  always_comb begin
    fw_ext = WW'(fwidth_r);
    if (fw_ext < WW'(egpbf_pkg::MIN_SIDE)) begin
      w_use = WW'(egpbf_pkg::MIN_SIDE);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w_use = WW'(MAX_WIDTH);
    end else begin
      w_use = fw_ext;
    end
    h_use = (fheight_r < RW'(egpbf_pkg::MIN_SIDE)) ? RW'(egpbf_pkg::MIN_SIDE) : fheight_r;
    h_ext = {1'b0, h_use};
  end

  // Position counters of the next input pixel.
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [RW-1:0]    row_r;
  logic [RW-1:0]    row_nxt;

  logic [COL_W-1:0] c_cur;
  logic [RW-1:0]    r_cur;
  logic [RW:0]      r_tmp;
  logic [RW:0]      r_inc;
  logic [WW-1:0]    c_inc;
  logic             col_wrap;
  logic             row_end;
  logic             emit_prev;
  logic             emit_last;
  logic             interior;

  always_comb begin
    // Fold counters that a smaller frame size left out of range.
    col_wrap = WW'(col_r) >= w_use;
    c_cur    = col_wrap ? '0 : col_r;
    r_tmp    = col_wrap ? ({1'b0, row_r} + 1'b1) : {1'b0, row_r};
    r_cur    = (r_tmp >= h_ext) ? '0 : r_tmp[RW-1:0];

    // Advance past the current pixel.
    c_inc   = WW'(c_cur) + 1'b1;
    r_inc   = {1'b0, r_cur} + 1'b1;
    row_end = c_inc >= w_use;
    col_nxt = row_end ? '0 : c_inc[COL_W-1:0];
    if (row_end) begin
      row_nxt = (r_inc >= h_ext) ? '0 : r_inc[RW-1:0];
    end else begin
      row_nxt = r_cur;
    end

    // What this pixel produces.
    emit_prev = r_cur != '0;
    emit_last = r_inc == h_ext;
    interior  = (r_cur > RW'(1)) && (c_cur != '0) && (c_inc < w_use);
  end

  logic in_accept;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line buffer addresses: center and right in the newer row, above and
  // left in the older row (left already holds the previous row there).
  logic [COL_W-1:0] addr_c;
  logic [COL_W-1:0] addr_r;
  logic [COL_W-1:0] addr_l;

  assign addr_c = c_cur;
  assign addr_r = c_cur + 1'b1;
  assign addr_l = c_cur - 1'b1;

  // Stage one: the accepted pixel while its line buffer reads return.
  logic                s1_valid_r;
  egpbf_pkg::pix_t     s1_px_r;
  logic [COL_W-1:0]    s1_col_r;
  logic [RW-1:0]       s1_row_r;
  logic                s1_prev_r;
  logic                s1_last_r;
  logic                s1_int_r;
  logic                s1_fwd_l_r;
  logic                s1_fwd_a_r;
  egpbf_pkg::pix_t     s1_fwd_d_r;

  egpbf_pkg::pix_t nw_rd_c;
  egpbf_pkg::pix_t nw_rd_r;
  egpbf_pkg::pix_t od_rd_a;
  egpbf_pkg::pix_t od_rd_l;

  // Newer row: the input pixel goes in as it is accepted.
  egpbf_ram #(
    .WIDTH (egpbf_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_newer_ram (
    .clk       (clk),
    .wr_en     (in_accept),
    .wr_addr   (addr_c),
    .wr_data   (in_pixel_in),
    .rd_addr_a (addr_c),
    .rd_addr_b (addr_r),
    .rd_data_a (nw_rd_c),
    .rd_data_b (nw_rd_r)
  );

  // Older row: the displaced newer entry moves in the following cycle.
  egpbf_ram #(
    .WIDTH (egpbf_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_older_ram (
    .clk       (clk),
    .wr_en     (s1_valid_r),
    .wr_addr   (s1_col_r),
    .wr_data   (nw_rd_c),
    .rd_addr_a (addr_c),
    .rd_addr_b (addr_l),
    .rd_data_a (od_rd_a),
    .rd_data_b (od_rd_l)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
    end
  end

  // Capture the pixel and forward the older-row write that lands in the
  // same cycle as this pixel's reads.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_px_r    <= in_pixel_in;
      s1_col_r   <= c_cur;
      s1_row_r   <= r_cur;
      s1_prev_r  <= emit_prev;
      s1_last_r  <= emit_last;
      s1_int_r   <= interior;
      s1_fwd_l_r <= s1_valid_r && (s1_col_r == addr_l);
      s1_fwd_a_r <= s1_valid_r && (s1_col_r == addr_c);
      s1_fwd_d_r <= nw_rd_c;
    end
  end

  // Edge test and blend.
  egpbf_pkg::pix_t px_left;
  egpbf_pkg::pix_t px_above;
  egpbf_pkg::pix_t px_filt;
  logic            is_edge;
  egpbf_pkg::res_t res_prev;
  egpbf_pkg::res_t res_self;

  always_comb begin
    px_left  = s1_fwd_l_r ? s1_fwd_d_r : od_rd_l;
    px_above = s1_fwd_a_r ? s1_fwd_d_r : od_rd_a;
    is_edge  = (colour_dist(nw_rd_r, s1_px_r)  > thresh_r) ||
               (colour_dist(nw_rd_r, px_above) > thresh_r) ||
               (colour_dist(px_left, s1_px_r)  > thresh_r) ||
               (colour_dist(px_left, px_above) > thresh_r);
    px_filt  = (s1_int_r && is_edge) ?
               blend(nw_rd_c, px_left, nw_rd_r, px_above, s1_px_r) : nw_rd_c;

    res_prev.pixel = px_filt;
    res_prev.row   = s1_row_r - 1'b1;
    res_prev.col   = egpbf_pkg::COL_O_W'(s1_col_r);
    res_prev.last  = !s1_last_r;

    res_self.pixel = s1_px_r;
    res_self.row   = s1_row_r;
    res_self.col   = egpbf_pkg::COL_O_W'(s1_col_r);
    res_self.last  = 1'b1;
  end

  // Result queue.
  egpbf_pkg::res_t oq_r [egpbf_pkg::OQ_DEPTH];
  logic [OAW-1:0]  wr_ptr_r;
  logic [OAW-1:0]  rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic [1:0]      s1_n;
  logic            pop;
  egpbf_pkg::res_t push_first;

  always_comb begin
    s1_n       = s1_valid_r ? (2'(s1_prev_r) + 2'(s1_last_r)) : 2'd0;
    push_first = s1_prev_r ? res_prev : res_self;
    pop        = (cnt_r != '0) && !out_stall;
    in_stall   = (cnt_r + CW'(s1_n)) > CW'(egpbf_pkg::OQ_DEPTH - 2);
  end

  always_ff @(posedge clk) begin
    if (s1_n != 2'd0) begin
      oq_r[wr_ptr_r] <= push_first;
    end
    if (s1_n == 2'd2) begin
      oq_r[wr_ptr_r + 1'b1] <= res_self;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OAW'(s1_n);
      rd_ptr_r <= rd_ptr_r + OAW'(pop);
      cnt_r    <= cnt_r + CW'(s1_n) - CW'(pop);
    end
  end

  // Output transaction from the queue head.
  egpbf_pkg::res_t head;
  assign head          = oq_r[rd_ptr_r];
  assign out_valid     = cnt_r != '0;
  assign out_pixel_out = head.pixel;
  assign out_row_out   = head.row;
  assign out_col_out   = head.col;
  assign out_run_last  = head.last;

endmodule

// ===== tb/sv/tb_edge_gated_pixel_blend_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge-gated pixel blend filter testbench
// Streams raster frames through the filter under random valid gaps and
// output stalls. A line-buffer predictor inside the bench computes every
// expected result, and a checker compares each result transaction in order.
// ----------------------------------------------------------------------------
module tb_edge_gated_pixel_blend_filter;

  // Index with no register behind it; writes to it must change nothing.
  localparam egpbf_pkg::cfg_idx_t CFG_SPARE_INDEX = 2'd3;

  // Pixel content styles for generated frames.
  typedef enum int {TONE_RANDOM, TONE_NEAR, TONE_EXTREME, TONE_MIXED} tone_t;

  // Ways a frame is interrupted by a register change.
  typedef enum int {CUT_THRESHOLD, CUT_HEIGHT, CUT_WIDTH} cut_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [egpbf_pkg::PIX_W-1:0]      in_pixel_in = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [egpbf_pkg::PIX_W-1:0]      out_pixel_out;
  logic [egpbf_pkg::ROW_W-1:0]      out_row_out;
  logic [egpbf_pkg::COL_O_W-1:0]    out_col_out;
  logic                             out_run_last;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  egpbf_pkg::cfg_idx_t              cfg_index = egpbf_pkg::CFG_EDGE_THRESHOLD;
  logic [egpbf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Handshake pressure, in percent of cycles.
  int send_idle_pct = 0;
  int stall_pct = 0;

  int items_sent = 0;
  int mismatches = 0;

  // Predictor copy of the registers, line buffers and raster position.
  int              pred_thr = egpbf_pkg::THR_RESET;
  int              pred_fw = egpbf_pkg::FW_RESET;
  int              pred_fh = egpbf_pkg::FH_RESET;
  egpbf_pkg::pix_t older_line [egpbf_pkg::MAX_WIDTH_DEF] = '{default: '0};
  egpbf_pkg::pix_t newer_line [egpbf_pkg::MAX_WIDTH_DEF] = '{default: '0};
  int              col_pos = 0;
  int              row_pos = 0;

  // Results the filter still owes, oldest first.
  egpbf_pkg::res_t due_pixels[$];

  edge_gated_pixel_blend_filter #(
    .MAX_WIDTH(egpbf_pkg::MAX_WIDTH_DEF)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel_in  (in_pixel_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel_out(out_pixel_out),
    .out_row_out  (out_row_out),
    .out_col_out  (out_col_out),
    .out_run_last (out_run_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Random back-pressure on the result channel.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Sum of absolute channel differences between two pixels.
  function automatic int color_dist(input egpbf_pkg::pix_t p, input egpbf_pkg::pix_t q);
    int s;
    int a;
    int b;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      a = p[egpbf_pkg::CH_W*k +: egpbf_pkg::CH_W];
      b = q[egpbf_pkg::CH_W*k +: egpbf_pkg::CH_W];
      s += (a > b) ? a - b : b - a;
    end
    return s;
  endfunction

  // Per channel: mean of the four neighbors, then mean with the center.
  function automatic egpbf_pkg::pix_t blend_px(input egpbf_pkg::pix_t ctr,
                                               input egpbf_pkg::pix_t lft,
                                               input egpbf_pkg::pix_t rgt,
                                               input egpbf_pkg::pix_t abv,
                                               input egpbf_pkg::pix_t blw);
    egpbf_pkg::pix_t acc;
    int              sum;
    int              avg;
    int              mid;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      sum = int'(lft[egpbf_pkg::CH_W*k +: egpbf_pkg::CH_W]) +
            int'(rgt[egpbf_pkg::CH_W*k +: egpbf_pkg::CH_W]) +
            int'(abv[egpbf_pkg::CH_W*k +: egpbf_pkg::CH_W]) +
            int'(blw[egpbf_pkg::CH_W*k +: egpbf_pkg::CH_W]);
      avg = sum / 4;
      mid = (avg + int'(ctr[egpbf_pkg::CH_W*k +: egpbf_pkg::CH_W])) / 2;
      acc[egpbf_pkg::CH_W*k +: egpbf_pkg::CH_W] = mid[egpbf_pkg::CH_W-1:0];
    end
    return acc;
  endfunction

  // Advance the predictor by one accepted pixel and queue what it releases.
  task automatic predict_filter(input egpbf_pkg::pix_t px);
    int              w;
    int              h;
    int              c;
    int              r;
    egpbf_pkg::pix_t ctr;
    egpbf_pkg::pix_t res;
    egpbf_pkg::pix_t lft;
    egpbf_pkg::pix_t rgt;
    egpbf_pkg::pix_t abv;
    egpbf_pkg::res_t rec;
    w = pred_fw;
    if (w < egpbf_pkg::MIN_SIDE) w = egpbf_pkg::MIN_SIDE;
    if (w > egpbf_pkg::MAX_WIDTH_DEF) w = egpbf_pkg::MAX_WIDTH_DEF;
    h = pred_fh;
    if (h < egpbf_pkg::MIN_SIDE) h = egpbf_pkg::MIN_SIDE;

    // Position left past a reduced size wraps before use.
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;

    // Delayed result for the pixel one row above.
    if (r > 0) begin
      ctr = newer_line[c];
      res = ctr;
      if (r > 1 && c > 0 && c + 1 < w) begin
        lft = older_line[c-1];
        rgt = newer_line[c+1];
        abv = older_line[c];
        if (color_dist(rgt, px) > pred_thr || color_dist(rgt, abv) > pred_thr ||
            color_dist(lft, px) > pred_thr || color_dist(lft, abv) > pred_thr) begin
          res = blend_px(ctr, lft, rgt, abv, px);
        end
      end
      rec.pixel = res;
      rec.row   = 16'(r - 1);
      rec.col   = 10'(c);
      rec.last  = (r + 1 != h);
      due_pixels.push_back(rec);
    end

    // The last row also passes each input straight through.
    if (r + 1 == h) begin
      rec.pixel = px;
      rec.row   = 16'(r);
      rec.col   = 10'(c);
      rec.last  = 1'b1;
      due_pixels.push_back(rec);
    end

    older_line[c] = newer_line[c];
    newer_line[c] = px;

    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  function automatic egpbf_pkg::pix_t rand_pixel(input tone_t tone,
                                                 input egpbf_pkg::pix_t base);
    egpbf_pkg::pix_t noise;
    noise = egpbf_pkg::pix_t'($urandom) & 24'h0F0F0F;
    case (tone)
      TONE_RANDOM:  return egpbf_pkg::pix_t'($urandom);
      TONE_NEAR:    return base ^ noise;
      TONE_EXTREME: return $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
      default:      return ($urandom_range(3) == 0) ? egpbf_pkg::pix_t'($urandom) :
                           base ^ noise;
    endcase
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // Send one pixel transaction, with an optional idle gap in front of it.
  task automatic send_pixel(input egpbf_pkg::pix_t px);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_pixel_in <= egpbf_pkg::pix_t'($urandom);
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_pixel_in <= px;
    do @(posedge clk); while (in_stall);
    predict_filter(px);
    items_sent++;
  endtask

  // Stop sending and wait until every owed result is out and the pipe is empty.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One register write transaction; the filter must be idle.
  task automatic write_reg(input egpbf_pkg::cfg_idx_t idx,
                           input logic [egpbf_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      egpbf_pkg::CFG_EDGE_THRESHOLD: pred_thr = val[egpbf_pkg::THR_W-1:0];
      egpbf_pkg::CFG_FRAME_WIDTH:    pred_fw = val[egpbf_pkg::FW_W-1:0];
      egpbf_pkg::CFG_FRAME_HEIGHT:   pred_fh = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [egpbf_pkg::CFG_DATA_W-1:0] thr_data,
                           input logic [egpbf_pkg::CFG_DATA_W-1:0] w_data,
                           input logic [egpbf_pkg::CFG_DATA_W-1:0] h_data);
    drain_results();
    write_reg(egpbf_pkg::CFG_EDGE_THRESHOLD, thr_data);
    write_reg(egpbf_pkg::CFG_FRAME_WIDTH, w_data);
    write_reg(egpbf_pkg::CFG_FRAME_HEIGHT, h_data);
  endtask

  // Send pixels until the raster position is back at the start of a frame.
  task automatic finish_frame(input tone_t tone, input egpbf_pkg::pix_t base);
    do send_pixel(rand_pixel(tone, base)); while (col_pos != 0 || row_pos != 0);
  endtask

  // 3x3 frames: threshold just below and at a full-contrast distance, flat white,
  // and clamped sizes.
  task automatic test_edge_contrast();
    egpbf_pkg::pix_t grid [9];
    grid = '{24'h000000, 24'hFFFFFF, 24'h000000,
             24'hFFFFFF, 24'h5A5AA5, 24'h000000,
             24'hFFFFFF, 24'h000000, 24'hFFFFFF};
    set_frame(16'd764, 16'd0, 16'd2);
    foreach (grid[i]) send_pixel(grid[i]);
    set_frame(16'd765, 16'd2, 16'd0);
    write_reg(CFG_SPARE_INDEX, 16'hA5A5);
    foreach (grid[i]) send_pixel(grid[i]);
    set_frame(16'd0, 16'd1, 16'd1);
    for (int i = 0; i < 9; i++) send_pixel(24'hFFFFFF);
  endtask

  // Tallest frame height, then cut to three rows while the row count is past it.
  task automatic test_tall_frame_cut_short();
    egpbf_pkg::pix_t base;
    base = egpbf_pkg::pix_t'($urandom);
    set_frame(16'($urandom_range(0, 200)), 16'd3, 16'hFFFF);
    for (int i = 0; i < 12; i++) send_pixel(rand_pixel(TONE_MIXED, base));
    drain_results();
    write_reg(egpbf_pkg::CFG_FRAME_HEIGHT, 16'd3);
    finish_frame(TONE_MIXED, base);
  endtask

  // Row width cut down to the current column in the middle of a row.
  task automatic test_row_cut_short();
    egpbf_pkg::pix_t base;
    base = egpbf_pkg::pix_t'($urandom);
    set_frame(16'($urandom_range(0, 200)), 16'd6, 16'd4);
    for (int i = 0; i < 9; i++) send_pixel(rand_pixel(TONE_MIXED, base));
    drain_results();
    write_reg(egpbf_pkg::CFG_FRAME_WIDTH, 16'd3);
    finish_frame(TONE_MIXED, base);
  endtask

  // Random small frames with random content; some are interrupted by a
  // register change partway through.
  task automatic test_random_frames(input int goal);
    int              start;
    int              thr;
    int              wdata;
    int              hdata;
    int              wuse;
    int              huse;
    int              n;
    tone_t           tone;
    egpbf_pkg::pix_t base;
    start = items_sent;
    while (items_sent - start < goal) begin
      tone = tone_t'($urandom_range(3));
      base = egpbf_pkg::pix_t'($urandom);
      case ($urandom_range(7))
        0: thr = 0;
        1: thr = 765;
        2: thr = 1023;
        default: thr = (tone == TONE_NEAR) ? $urandom_range(0, 100) : $urandom_range(0, 765);
      endcase
      case ($urandom_range(9))
        0: wdata = $urandom_range(0, 2);
        1: wdata = $urandom_range(17, 64);
        default: wdata = $urandom_range(3, 16);
      endcase
      hdata = ($urandom_range(5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      wuse = (wdata < egpbf_pkg::MIN_SIDE) ? egpbf_pkg::MIN_SIDE : wdata;
      huse = (hdata < egpbf_pkg::MIN_SIDE) ? egpbf_pkg::MIN_SIDE : hdata;
      set_frame(16'(($urandom_range(63) << egpbf_pkg::THR_W) | thr),
                16'(($urandom_range(31) << egpbf_pkg::FW_W) | wdata), 16'(hdata));

      if ($urandom_range(7) == 0) begin
        n = $urandom_range(1, wuse * huse - 1);
        for (int i = 0; i < n; i++) send_pixel(rand_pixel(tone, base));
        drain_results();
        case (cut_t'($urandom_range(2)))
          CUT_THRESHOLD: write_reg(egpbf_pkg::CFG_EDGE_THRESHOLD, 16'($urandom));
          CUT_HEIGHT:    write_reg(egpbf_pkg::CFG_FRAME_HEIGHT, 16'($urandom_range(0, 8)));
          default:       write_reg(egpbf_pkg::CFG_FRAME_WIDTH, 16'($urandom_range(0, wuse)));
        endcase
      end
      finish_frame(tone, base);
    end
  endtask

  // Widest rows: width written past the buffer depth, height below the minimum.
  // One full row and the start of the next, then the width is cut to close
  // the frame.
  task automatic test_widest_rows();
    egpbf_pkg::pix_t base;
    base = egpbf_pkg::pix_t'($urandom);
    set_frame(16'($urandom_range(0, 765)), 16'hFFFF, 16'd0);
    for (int i = 0; i < egpbf_pkg::MAX_WIDTH_DEF + 8; i++) begin
      send_pixel(rand_pixel(TONE_MIXED, base));
    end
    drain_results();
    write_reg(egpbf_pkg::CFG_FRAME_WIDTH, 16'd3);
    finish_frame(TONE_MIXED, base);
  endtask

  // Compare each accepted result transaction with the oldest owed result.
  always @(posedge clk) begin : check_results
    egpbf_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_pixels.size() == 0) begin
        log_mismatch($sformatf("unexpected result: pixel %06h row %0d col %0d last %0b",
                               out_pixel_out, out_row_out, out_col_out, out_run_last));
      end else begin
        want = due_pixels.pop_front();
        if (out_pixel_out !== want.pixel || out_row_out !== want.row ||
            out_col_out !== want.col || out_run_last !== want.last) begin
          log_mismatch($sformatf(
            "mismatch: expected pixel %06h row %0d col %0d last %0b, got %06h %0d %0d %0b",
            want.pixel, want.row, want.col, want.last,
            out_pixel_out, out_row_out, out_col_out, out_run_last));
        end
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 17;
    stall_pct = 77;
    test_edge_contrast();
    test_tall_frame_cut_short();
    test_row_cut_short();
    test_random_frames(130);

    send_idle_pct = 77;
    stall_pct = 17;
    test_random_frames(130);

    send_idle_pct = 0;
    stall_pct = 0;
    test_random_frames(130);
    test_widest_rows();

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== edge_gated_pixel_blend_filter.f =====
sv/egpbf_pkg.sv
sv/egpbf_ram.sv
sv/edge_gated_pixel_blend_filter.sv
tb/sv/tb_edge_gated_pixel_blend_filter.sv
